// File: hw/rtl/kst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kst_pkg
// Shared constants, codes and types of the keysym to scancode translator.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int DIRECT_SYMBOLS_DEF = 512;
  localparam int EXTRA_ENTRIES_DEF  = 256;
  localparam int LOCK_RANGES_DEF    = 8;

  localparam logic [31:0] SYM_SHIFT_L   = 32'h0000_FFE1;
  localparam logic [31:0] SYM_SHIFT_R   = 32'h0000_FFE2;
  localparam logic [31:0] SYM_NUM_LOCK  = 32'h0000_FF7F;
  localparam logic [31:0] SYM_CAPS_LOCK = 32'h0000_FFE5;
  localparam logic [31:0] SYM_UPPER_A   = 32'h0000_0041;
  localparam logic [31:0] SYM_UPPER_Z   = 32'h0000_005A;

  localparam logic [7:0]  CODE_GREY    = 8'h80;
  localparam logic [7:0]  CODE_PREFIX  = 8'hE0;
  localparam logic [7:0]  CODE_KEYMASK = 8'h7F;
  localparam logic [7:0]  CODE_UP      = 8'h80;
  localparam logic [15:0] CODE_NONE    = 16'hFFFF;
  localparam logic [31:0] SYM_MAX      = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_MAP   = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  // queued command between front and back
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key_symbol;
    logic        key_down;
    logic [15:0] table_code;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DMAP_RD,
    ST_XSCAN,
    ST_XWAIT,
    ST_RSCAN,
    ST_DECIDE,
    ST_LOOK,
    ST_LOOK_WAIT,
    ST_EMIT,
    ST_DONE
  } back_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/keysym_to_scancode_translator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keysym_to_scancode_translator
// Key symbol and up/down events in, set-1 scancode bytes out.
// ----------------------------------------------------------------------------
// Usage: in_* carries one command (key event, mapping add, numlock range add)
// per transfer; out_* returns one result per transfer, out_last_of_run marks
// the final result of a command. A front queue of two entries takes commands
// while the back end works, so in_stall rises only when both slots are full.
// Flow: a mapping add answers without a scan; a range add walks the
// ranges from the newest, one per cycle.
// A key event walks the ranges, then for each looked-up symbol (up to five)
// reads the direct map or scans the extra table entry by entry.
// After reset the direct map is cleared one entry a cycle, while commands
// wait in the queue. A stalled result holds the back end in place; results
// are never dropped.
// ----------------------------------------------------------------------------
module keysym_to_scancode_translator #(
  parameter int DIRECT_SYMBOLS = kst_pkg::DIRECT_SYMBOLS_DEF,
  parameter int EXTRA_ENTRIES  = kst_pkg::EXTRA_ENTRIES_DEF,
  parameter int LOCK_RANGES    = kst_pkg::LOCK_RANGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_key_symbol,
  input  wire logic        in_key_down,
  input  wire logic [15:0] in_table_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_scan_byte,
  output logic             out_last_of_run
);

  logic          q_valid, q_take;
  kst_pkg::cmd_t q_cmd;

  // accept and queue commands
  kst_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_key_symbol,
    .in_key_down, .in_table_code, .q_valid, .q_cmd, .q_take
  );

  // execute commands
  kst_back #(
    .DIRECT_SYMBOLS(DIRECT_SYMBOLS), .EXTRA_ENTRIES(EXTRA_ENTRIES),
    .LOCK_RANGES(LOCK_RANGES)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_take, .out_valid, .out_stall,
    .out_result_kind, .out_scan_byte, .out_last_of_run
  );

endmodule
`default_nettype wire

// File: hw/rtl/kst_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kst_front
// Input stage and two-entry command queue toward the back end.
// ----------------------------------------------------------------------------
module kst_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_opcode,
  input  wire logic [31:0]   in_key_symbol,
  input  wire logic          in_key_down,
  input  wire logic [15:0]   in_table_code,
  output logic               q_valid,
  output kst_pkg::cmd_t      q_cmd,
  input  wire logic          q_take
);

  kst_pkg::cmd_t q_mem_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  kst_pkg::cmd_t in_cmd;

  // drop unused opcodes at the door: they cause nothing
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && (in_opcode != kst_pkg::OP_NONE);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rp_r];

  always_comb begin
    in_cmd.opcode     = in_opcode;
    in_cmd.key_symbol = in_key_symbol;
    in_cmd.key_down   = in_key_down;
    in_cmd.table_code = in_table_code;
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ (q_take && q_valid);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_take && q_valid};
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold queued commands
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= in_cmd;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("take from empty queue");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/kst_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kst_back
// Executes queued commands: table loads, range merges and scancode runs.
// ----------------------------------------------------------------------------
module kst_back #(
  parameter int DIRECT_SYMBOLS = kst_pkg::DIRECT_SYMBOLS_DEF,
  parameter int EXTRA_ENTRIES  = kst_pkg::EXTRA_ENTRIES_DEF,
  parameter int LOCK_RANGES    = kst_pkg::LOCK_RANGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  kst_pkg::cmd_t      q_cmd,
  output logic               q_take,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_scan_byte,
  output logic               out_last_of_run
);

  localparam int DW = $clog2(DIRECT_SYMBOLS);
  localparam int XW = $clog2(EXTRA_ENTRIES);
  localparam int RW = $clog2(LOCK_RANGES) > 0 ? $clog2(LOCK_RANGES) : 1;
  localparam logic [DW:0] DCNT_LAST = (DW+1)'(DIRECT_SYMBOLS - 1);
  localparam logic [XW:0] XFULL = (XW+1)'(EXTRA_ENTRIES);
  localparam logic [RW:0] RFULL = (RW+1)'(LOCK_RANGES);
  localparam logic [31:0] DSYM  = 32'(DIRECT_SYMBOLS);

  // memories
  logic [15:0] dmap_mem [DIRECT_SYMBOLS];
  logic [31:0] xsym_mem [EXTRA_ENTRIES];
  logic [15:0] xcode_mem [EXTRA_ENTRIES];
  logic [31:0] rlo_r [LOCK_RANGES];
  logic [31:0] rhi_r [LOCK_RANGES];

  kst_pkg::back_state_t st_r, st_nxt;
  kst_pkg::cmd_t cmd_r;
  logic [DW:0]  clr_r;
  logic [XW:0]  xcnt_r;
  logic [RW:0]  rcnt_r;
  logic [XW:0]  xi_r;
  logic [RW:0]  ri_r;
  logic         shift_r, num_r, caps_r;
  logic         want_num_r, found_r;
  logic [15:0]  dmap_rd_r, xcode_rd_r;
  logic [31:0]  xsym_rd_r;
  logic [15:0]  code_r;
  // phases of a key run: 0 num press,1 num rel,2 caps press,3 caps rel,4 key
  logic [2:0]   ph_r;
  logic         pfx_r;        // prefix byte already sent for this phase
  logic         need_caps_r;
  logic [31:0]  lsym;
  logic         ldown;
  logic         direct_hit;

  logic         ov_r;
  logic [1:0]   okind_r;
  logic [7:0]   obyte_r;
  logic         olast_r;
  logic         emit;
  logic [1:0]   ekind;
  logic [7:0]   ebyte;
  logic         elast;
  logic         oslot;

  assign out_valid       = ov_r;
  assign out_result_kind = okind_r;
  assign out_scan_byte   = obyte_r;
  assign out_last_of_run = olast_r;
  assign oslot = !ov_r || !out_stall;

  // symbol of the current key phase
  always_comb begin
    unique case (ph_r)
      3'd0, 3'd1: lsym = kst_pkg::SYM_NUM_LOCK;
      3'd2, 3'd3: lsym = kst_pkg::SYM_CAPS_LOCK;
      default:    lsym = cmd_r.key_symbol;
    endcase
    ldown      = (ph_r == 3'd0) || (ph_r == 3'd2) || (ph_r == 3'd4 && cmd_r.key_down);
    direct_hit = (lsym < DSYM);
  end

  logic rng_hit, rng_lo_adj, rng_hi_adj;
  logic [RW-1:0] rk;
  always_comb begin
    rk         = RW'(ri_r - 1'b1);
    rng_hit    = (cmd_r.key_symbol >= rlo_r[rk]) && (cmd_r.key_symbol <= rhi_r[rk]);
    rng_lo_adj = (rlo_r[rk] != 32'd0) && (cmd_r.key_symbol == rlo_r[rk] - 32'd1);
    rng_hi_adj = (rhi_r[rk] != kst_pkg::SYM_MAX) &&
                 (cmd_r.key_symbol == rhi_r[rk] + 32'd1);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      kst_pkg::ST_CLEAR:     if (clr_r == DCNT_LAST) st_nxt = kst_pkg::ST_IDLE;
      kst_pkg::ST_IDLE:      if (q_valid) begin
        if (q_cmd.opcode == kst_pkg::OP_RANGE) st_nxt = kst_pkg::ST_RSCAN;
        else if (q_cmd.opcode == kst_pkg::OP_MAP) st_nxt = kst_pkg::ST_DONE;
        else st_nxt = kst_pkg::ST_RSCAN;
      end
      kst_pkg::ST_RSCAN: begin
        if (cmd_r.opcode == kst_pkg::OP_RANGE) begin
          if (ri_r == '0 || rng_hit || rng_lo_adj || rng_hi_adj) st_nxt = kst_pkg::ST_DONE;
        end else if (ri_r == '0 || rng_hit) st_nxt = kst_pkg::ST_DECIDE;
      end
      kst_pkg::ST_DECIDE:    st_nxt = kst_pkg::ST_LOOK;
      kst_pkg::ST_LOOK:      st_nxt = direct_hit ? kst_pkg::ST_DMAP_RD : kst_pkg::ST_XSCAN;
      kst_pkg::ST_DMAP_RD:   st_nxt = kst_pkg::ST_EMIT;
      kst_pkg::ST_XSCAN:     st_nxt = (xi_r == xcnt_r) ? kst_pkg::ST_EMIT : kst_pkg::ST_XWAIT;
      kst_pkg::ST_XWAIT:     if (xsym_rd_r == lsym) st_nxt = kst_pkg::ST_EMIT;
                             else st_nxt = kst_pkg::ST_XSCAN;
      kst_pkg::ST_EMIT:      if (oslot && !((code_r[7]) && !pfx_r)) begin
        if (ph_r == 3'd4) st_nxt = kst_pkg::ST_IDLE;
        else st_nxt = kst_pkg::ST_LOOK;
      end
      kst_pkg::ST_DONE:      if (oslot) st_nxt = kst_pkg::ST_IDLE;
      default:               st_nxt = kst_pkg::ST_IDLE;
    endcase
  end

  // output transfer selection
  always_comb begin
    emit  = 1'b0;
    ekind = kst_pkg::KIND_BYTE;
    ebyte = 8'd0;
    elast = 1'b0;
    q_take = (st_r == kst_pkg::ST_IDLE) && q_valid;
    unique case (st_r)
      kst_pkg::ST_EMIT: begin
        emit = oslot;
        if (code_r[7] && !pfx_r) begin
          ebyte = kst_pkg::CODE_PREFIX;
        end else begin
          ebyte = (code_r[7:0] & kst_pkg::CODE_KEYMASK) | (ldown ? 8'd0 : kst_pkg::CODE_UP);
          elast = (ph_r == 3'd4);
        end
      end
      kst_pkg::ST_DONE: begin
        emit  = oslot;
        ekind = found_r ? kst_pkg::KIND_OK : kst_pkg::KIND_FULL;
        elast = 1'b1;
      end
      default: ;
    endcase
  end

  // advance next phase after a finished byte
  function automatic logic [2:0] next_ph(input logic [2:0] p, input logic nc);
    logic [2:0] r;
    r = p + 3'd1;
    if (r == 3'd2 && !nc) r = 3'd4;
    return r;
  endfunction

  // main control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= kst_pkg::ST_CLEAR;
      clr_r   <= '0;
      xcnt_r  <= '0;
      rcnt_r  <= '0;
      shift_r <= 1'b0;
      num_r   <= 1'b0;
      caps_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (emit) ov_r <= 1'b1;
      unique case (st_r)
        kst_pkg::ST_CLEAR: clr_r <= clr_r + 1'b1;
        kst_pkg::ST_IDLE: if (q_valid) begin
          ri_r <= rcnt_r;
          xi_r <= '0;
          found_r <= 1'b1;
          if (q_cmd.opcode == kst_pkg::OP_MAP && q_cmd.key_symbol >= DSYM) begin
            if (xcnt_r == XFULL) found_r <= 1'b0;
            else xcnt_r <= xcnt_r + 1'b1;
          end
          if (q_cmd.opcode == kst_pkg::OP_KEY) begin
            if (q_cmd.key_symbol == kst_pkg::SYM_SHIFT_L ||
                q_cmd.key_symbol == kst_pkg::SYM_SHIFT_R) shift_r <= q_cmd.key_down;
            else if (q_cmd.key_symbol == kst_pkg::SYM_NUM_LOCK) num_r <= num_r ^ q_cmd.key_down;
            else if (q_cmd.key_symbol == kst_pkg::SYM_CAPS_LOCK)
              caps_r <= caps_r ^ q_cmd.key_down;
          end
        end
        kst_pkg::ST_RSCAN: begin
          if (cmd_r.opcode == kst_pkg::OP_RANGE) begin
            if (ri_r == '0) begin
              if (rcnt_r == RFULL) found_r <= 1'b0;
              else begin
                rcnt_r <= rcnt_r + 1'b1;
                rlo_r[rcnt_r[RW-1:0]] <= cmd_r.key_symbol;
                rhi_r[rcnt_r[RW-1:0]] <= cmd_r.key_symbol;
              end
            end else if (!rng_hit && rng_lo_adj) rlo_r[rk] <= cmd_r.key_symbol;
            else if (!rng_hit && rng_hi_adj) rhi_r[rk] <= cmd_r.key_symbol;
            else if (!rng_hit) ri_r <= ri_r - 1'b1;
          end else begin
            want_num_r <= (ri_r != '0) && rng_hit;
            if (ri_r != '0 && !rng_hit) ri_r <= ri_r - 1'b1;
          end
        end
        kst_pkg::ST_DECIDE: begin
          if (!cmd_r.key_down) begin
            need_caps_r <= 1'b0; ph_r <= 3'd4;
          end else begin
            need_caps_r <= (caps_r != ((cmd_r.key_symbol >= kst_pkg::SYM_UPPER_A) &&
                           (cmd_r.key_symbol <= kst_pkg::SYM_UPPER_Z) && !shift_r));
            if (num_r != want_num_r) ph_r <= 3'd0;
            else if (caps_r != ((cmd_r.key_symbol >= kst_pkg::SYM_UPPER_A) &&
                     (cmd_r.key_symbol <= kst_pkg::SYM_UPPER_Z) && !shift_r)) ph_r <= 3'd2;
            else ph_r <= 3'd4;
            num_r  <= want_num_r;
            caps_r <= (cmd_r.key_symbol >= kst_pkg::SYM_UPPER_A) &&
                      (cmd_r.key_symbol <= kst_pkg::SYM_UPPER_Z) && !shift_r;
          end
        end
        kst_pkg::ST_LOOK: begin
          xi_r   <= '0;
          pfx_r  <= 1'b0;
        end
        kst_pkg::ST_DMAP_RD: code_r <= dmap_rd_r;
        kst_pkg::ST_XSCAN: begin
          code_r <= kst_pkg::CODE_NONE;
          xi_r   <= xi_r + 1'b1;
        end
        kst_pkg::ST_XWAIT: if (xsym_rd_r == lsym) code_r <= xcode_rd_r;
        kst_pkg::ST_EMIT: if (oslot) begin
          if (code_r[7] && !pfx_r) pfx_r <= 1'b1;
          else ph_r <= next_ph(ph_r, need_caps_r);
        end
        default: ;
      endcase
    end
  end

  // hold the command and the output register
  always_ff @(posedge clk) begin
    if (q_take) cmd_r <= q_cmd;
    if (emit) begin
      okind_r <= ekind;
      obyte_r <= ebyte;
      olast_r <= elast;
    end
  end

  // direct map: clearing pass and loads share the write port
  always_ff @(posedge clk) begin
    if (st_r == kst_pkg::ST_CLEAR) dmap_mem[clr_r[DW-1:0]] <= kst_pkg::CODE_NONE;
    else if (q_take && q_cmd.opcode == kst_pkg::OP_MAP && q_cmd.key_symbol < DSYM)
      dmap_mem[q_cmd.key_symbol[DW-1:0]] <= q_cmd.table_code;
    dmap_rd_r <= dmap_mem[lsym[DW-1:0]];
  end

  // extra table: append port and scan read port
  always_ff @(posedge clk) begin
    if (q_take && q_cmd.opcode == kst_pkg::OP_MAP && q_cmd.key_symbol >= DSYM &&
        xcnt_r != XFULL) begin
      xsym_mem[xcnt_r[XW-1:0]]  <= q_cmd.key_symbol;
      xcode_mem[xcnt_r[XW-1:0]] <= q_cmd.table_code;
    end
    xsym_rd_r  <= xsym_mem[xi_r[XW-1:0]];
    xcode_rd_r <= xcode_mem[xi_r[XW-1:0]];
  end

`ifndef SYNTH
  a_xcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    xcnt_r <= XFULL) else $error("extra count overrun");
  a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= RFULL) else $error("range count overrun");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == kst_pkg::ST_IDLE) else $error("take while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> oslot) else $error("overwrote pending result");
`endif

endmodule
`default_nettype wire
